@@ sv/velocity_pi_ramp_controller_macros.svh @@
// assertion macros for the velocity pi ramp controller
`ifndef VELOCITY_PI_RAMP_CONTROLLER_MACROS_SVH
`define VELOCITY_PI_RAMP_CONTROLLER_MACROS_SVH

// property checked on every clock edge outside reset
`define VPRC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every clock edge outside reset
`define VPRC_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

@@ sv/vprc_pkg.sv @@
// package: widths, constants and state type of the velocity pi ramp controller
package vprc_pkg;

    localparam int MOTORS_DEFAULT = 2;

    localparam int GAIN_W  = 24;
    localparam int VLIM_W  = 23;
    localparam int RAMP_W  = 28;
    localparam int CFG_W   = 28;
    localparam int ERR_W   = 32;
    localparam int EUS_W   = 20;
    localparam int TS_W    = 19;
    localparam int VOLT_W  = 24;

    localparam int MUL_AW  = 40;
    localparam int MUL_BW  = 33;
    localparam int MUL_PW  = MUL_AW + MUL_BW;
    localparam int DIV_NW  = 59;
    localparam int DIV_DW  = 20;

    localparam logic [DIV_DW-1:0] US_PER_S      = DIV_DW'(1000000);
    localparam logic [EUS_W-1:0]  TS_MAX_US     = EUS_W'(500000);
    localparam logic [TS_W-1:0]   TS_DEFAULT_US = TS_W'(1000);

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(4456);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(2425);
    localparam logic [VLIM_W-1:0] VLIM_RST       = VLIM_W'(786432);
    localparam logic [RAMP_W-1:0] RAMP_RST       = RAMP_W'(6553600);

    localparam logic [1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] CFG_INTEG_GAIN = 2'd1;
    localparam logic [1:0] CFG_VLIM       = 2'd2;
    localparam logic [1:0] CFG_RAMP       = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_G,
        ST_DIV_G,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_S,
        ST_DIV_S,
        ST_CLAMP_I,
        ST_CLAMP_O,
        ST_RAMP,
        ST_DONE
    } vprc_state_t;

    typedef struct packed {
        logic start;
    } vprc_unit_ctrl_t;

    typedef struct packed {
        logic busy;
    } vprc_unit_stat_t;

endpackage

@@ sv/vprc_mul.sv @@
// bit-serial shift-add multiplier, one multiplier bit per cycle
module vprc_mul
    import vprc_pkg::*;
#(
    parameter int AW = MUL_AW,
    parameter int BW = MUL_BW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  vprc_unit_ctrl_t      ctrl,
    output vprc_unit_stat_t      stat,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic [AW+BW-1:0]     product
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic [AW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [AW+BW-1:0] acc_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic [AW:0]      sum;

    assign sum = {1'b0, acc_reg[AW+BW-1:BW]} + (b_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(BW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {sum, acc_reg[BW-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign product   = acc_reg;

endmodule

@@ sv/vprc_div.sv @@
// bit-serial restoring divider by the constant one million
module vprc_div
    import vprc_pkg::*;
#(
    parameter int NW = DIV_NW
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  vprc_unit_ctrl_t  ctrl,
    output vprc_unit_stat_t  stat,
    input  logic [NW-1:0]    num,
    output logic [NW-1:0]    quot
);

    localparam int CW = $clog2(NW);

    logic [NW-1:0]     num_reg;
    logic [NW-1:0]     quot_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = (trial >= {1'b0, US_PER_S});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            num_reg  <= num;
            quot_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= num_reg << 1;
            quot_reg <= {quot_reg[NW-2:0], fits};
            rem_reg  <= fits ? DIV_DW'(trial - {1'b0, US_PER_S}) : trial[DIV_DW-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign quot      = quot_reg;

endmodule

@@ sv/velocity_pi_ramp_controller.sv @@
// one transaction at a time: s_tready is high only in idle, and the shared bit-serial
// multiplier (four products) and the constant divider (two quotients) are used in turn
// by the sequencer before the result reaches the output register
// a finished result waits in the output register while the next transaction is taken
// reset: asynchronous active low, clears per-motor state and loads the register defaults
module velocity_pi_ramp_controller
    import vprc_pkg::*;
#(
    parameter int MOTORS = MOTORS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // vel_error[31:0], elapsed_us[51:32], zero pad
    input  logic        s_tuser,   // motor_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // drive_voltage[23:0]
    output logic [2:0]  m_tuser,   // motor_tag, clamped, ramp_limited
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [CFG_W-1:0] cfg_data
);

`include "velocity_pi_ramp_controller_macros.svh"

    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

    vprc_state_t state_reg, state_next;
    logic        started_reg;

    logic [GAIN_W-1:0] prop_gain_reg, integ_gain_reg;
    logic [VLIM_W-1:0] vlim_reg;
    logic [RAMP_W-1:0] ramp_reg;

    logic signed [VOLT_W-1:0] integ_mem_reg [MOTORS];
    logic signed [ERR_W-1:0]  err_mem_reg   [MOTORS];
    logic signed [VOLT_W-1:0] out_mem_reg   [MOTORS];

    logic                     tag_reg;
    logic [MW-1:0]            idx_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic [TS_W-1:0]          ts_reg;
    logic [38:0]              g_reg;
    logic signed [40:0]       p_reg;
    logic signed [40:0]       inc_reg;
    logic [RAMP_W-1:0]        step_reg;
    logic signed [VOLT_W-1:0] integ_reg;
    logic signed [VOLT_W-1:0] sum_reg;
    logic signed [VOLT_W-1:0] outv_reg;
    logic                     clamp_reg;
    logic                     ramped_reg;

    logic                     m_tvalid_reg;
    logic [23:0]              m_tdata_reg;
    logic [2:0]               m_tuser_reg;

    vprc_unit_ctrl_t    mul_ctrl, div_ctrl;
    vprc_unit_stat_t    mul_stat, div_stat;
    logic [MUL_AW-1:0]  mul_a;
    logic [MUL_BW-1:0]  mul_b;
    logic [MUL_PW-1:0]  mul_p;
    logic [DIV_NW-1:0]  div_n;
    logic [DIV_NW-1:0]  div_q;

    logic               op_done;
    logic               out_free;
    logic               accept;
    logic [EUS_W-1:0]   eus_in;
    logic [TS_W-1:0]    ts_in;
    logic signed [ERR_W:0]   s_val;
    logic [ERR_W:0]          s_mag;
    logic [ERR_W-1:0]        e_mag;
    logic signed [41:0]      integ_raw;
    logic signed [41:0]      sum_raw;
    logic signed [41:0]      lim_ext;
    logic signed [VOLT_W:0]  d_val;
    logic signed [RAMP_W+1:0] d_ext;
    logic signed [RAMP_W+1:0] step_ext;
    logic [39:0]             p_mag;
    logic [39:0]             inc_mag;

    vprc_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .stat    (mul_stat),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    vprc_div #(.NW(DIV_NW)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat),
        .num   (div_n),
        .quot  (div_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign eus_in   = s_tdata[51:32];
    assign ts_in    = ((eus_in == '0) || (eus_in > TS_MAX_US)) ? TS_DEFAULT_US
                                                               : eus_in[TS_W-1:0];

    assign s_val = ERR_W'(0) + $signed({e_reg[ERR_W-1], e_reg})
                 + $signed({err_mem_reg[idx_reg][ERR_W-1], err_mem_reg[idx_reg]});
    assign s_mag = s_val[ERR_W] ? (ERR_W+1)'(-s_val) : s_val;
    assign e_mag = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : e_reg;
    assign p_mag   = mul_p[55:16];
    assign inc_mag = mul_p[72:33];

    assign lim_ext   = $signed({19'd0, vlim_reg});
    assign integ_raw = 42'(inc_reg) + 42'(integ_mem_reg[idx_reg]);
    assign sum_raw   = 42'(p_reg) + 42'(integ_reg);
    assign d_val     = (VOLT_W+1)'(sum_reg) - (VOLT_W+1)'(out_mem_reg[idx_reg]);
    assign d_ext     = (RAMP_W+2)'(d_val);
    assign step_ext  = $signed({2'b00, step_reg});

    always_comb
    begin
        case (state_reg)
            ST_MUL_G, ST_MUL_P, ST_MUL_I, ST_MUL_S: op_done = started_reg && !mul_stat.busy;
            ST_DIV_G, ST_DIV_S:                     op_done = started_reg && !div_stat.busy;
            default:                                op_done = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept) state_next = ST_MUL_G;
            ST_MUL_G:   if (op_done) state_next = ST_DIV_G;
            ST_DIV_G:   if (op_done) state_next = ST_MUL_P;
            ST_MUL_P:   if (op_done) state_next = ST_MUL_I;
            ST_MUL_I:   if (op_done) state_next = ST_MUL_S;
            ST_MUL_S:   if (op_done) state_next = ST_DIV_S;
            ST_DIV_S:   if (op_done) state_next = ST_CLAMP_I;
            ST_CLAMP_I: state_next = ST_CLAMP_O;
            ST_CLAMP_O: state_next = ST_RAMP;
            ST_RAMP:    state_next = ST_DONE;
            ST_DONE:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit controls and operands
    always_comb
    begin
        mul_ctrl.start = 1'b0;
        div_ctrl.start = 1'b0;
        mul_a = '0;
        mul_b = '0;
        div_n = '0;
        case (state_reg)
            ST_MUL_G:
            begin
                mul_ctrl.start = !started_reg;
                mul_a = MUL_AW'(integ_gain_reg);
                mul_b = MUL_BW'(ts_reg);
            end
            ST_DIV_G:
            begin
                div_ctrl.start = !started_reg;
                div_n = {mul_p[42:0], 16'd0};
            end
            ST_MUL_P:
            begin
                mul_ctrl.start = !started_reg;
                mul_a = MUL_AW'(prop_gain_reg);
                mul_b = MUL_BW'(e_mag);
            end
            ST_MUL_I:
            begin
                mul_ctrl.start = !started_reg;
                mul_a = MUL_AW'(g_reg);
                mul_b = s_mag;
            end
            ST_MUL_S:
            begin
                mul_ctrl.start = !started_reg;
                mul_a = MUL_AW'(ramp_reg);
                mul_b = MUL_BW'(ts_reg);
            end
            ST_DIV_S:
            begin
                div_ctrl.start = !started_reg;
                div_n = DIV_NW'(mul_p[46:0]);
            end
            default:
            begin
                mul_ctrl.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            started_reg <= (state_next == state_reg);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            vlim_reg       <= VLIM_RST;
            ramp_reg       <= RAMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN: integ_gain_reg <= cfg_data[GAIN_W-1:0];
                CFG_VLIM:       vlim_reg       <= cfg_data[VLIM_W-1:0];
                CFG_RAMP:       ramp_reg       <= cfg_data[RAMP_W-1:0];
                default:        ramp_reg       <= ramp_reg;
            endcase
        end
    end

    // per-motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MOTORS; m++)
            begin
                integ_mem_reg[m] <= '0;
                err_mem_reg[m]   <= '0;
                out_mem_reg[m]   <= '0;
            end
        end
        else if (state_reg == ST_RAMP)
        begin
            integ_mem_reg[idx_reg] <= integ_reg;
            err_mem_reg[idx_reg]   <= e_reg;
            if (d_ext > step_ext)
            begin
                out_mem_reg[idx_reg] <= VOLT_W'(out_mem_reg[idx_reg] + VOLT_W'(step_reg));
            end
            else if (d_ext < -step_ext)
            begin
                out_mem_reg[idx_reg] <= VOLT_W'(out_mem_reg[idx_reg] - VOLT_W'(step_reg));
            end
            else
            begin
                out_mem_reg[idx_reg] <= sum_reg;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                tag_reg <= s_tuser;
                idx_reg <= (MOTORS > 1) ? MW'(s_tuser) : '0;
                e_reg   <= $signed(s_tdata[31:0]);
                ts_reg  <= ts_in;
            end
            ST_DIV_G:
            begin
                if (op_done) g_reg <= div_q[38:0];
            end
            ST_MUL_P:
            begin
                if (op_done) p_reg <= e_reg[ERR_W-1] ? -$signed({1'b0, p_mag})
                                                     : $signed({1'b0, p_mag});
            end
            ST_MUL_I:
            begin
                if (op_done) inc_reg <= s_val[ERR_W] ? -$signed({1'b0, inc_mag})
                                                     : $signed({1'b0, inc_mag});
            end
            ST_DIV_S:
            begin
                if (op_done) step_reg <= div_q[RAMP_W-1:0];
            end
            ST_CLAMP_I:
            begin
                if (integ_raw > lim_ext)
                begin
                    integ_reg <= VOLT_W'(lim_ext);
                    clamp_reg <= 1'b1;
                end
                else if (integ_raw < -lim_ext)
                begin
                    integ_reg <= VOLT_W'(-lim_ext);
                    clamp_reg <= 1'b1;
                end
                else
                begin
                    integ_reg <= VOLT_W'(integ_raw);
                    clamp_reg <= 1'b0;
                end
            end
            ST_CLAMP_O:
            begin
                if (sum_raw > lim_ext)
                begin
                    sum_reg   <= VOLT_W'(lim_ext);
                    clamp_reg <= 1'b1;
                end
                else if (sum_raw < -lim_ext)
                begin
                    sum_reg   <= VOLT_W'(-lim_ext);
                    clamp_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= VOLT_W'(sum_raw);
                end
            end
            ST_RAMP:
            begin
                if (d_ext > step_ext)
                begin
                    outv_reg   <= VOLT_W'(out_mem_reg[idx_reg] + VOLT_W'(step_reg));
                    ramped_reg <= 1'b1;
                end
                else if (d_ext < -step_ext)
                begin
                    outv_reg   <= VOLT_W'(out_mem_reg[idx_reg] - VOLT_W'(step_reg));
                    ramped_reg <= 1'b1;
                end
                else
                begin
                    outv_reg   <= sum_reg;
                    ramped_reg <= 1'b0;
                end
            end
            default:
            begin
                ts_reg <= ts_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= outv_reg;
            m_tuser_reg <= {ramped_reg, clamp_reg, tag_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `VPRC_ASSERT(a_units_exclusive, !(mul_stat.busy && div_stat.busy), "mul and div both busy")
    `VPRC_ASSERT_IMP(a_idle_units, s_tready, !mul_stat.busy && !div_stat.busy, "unit busy in idle")
    `VPRC_ASSERT(a_accept_leaves_idle, accept |=> !s_tready, "idle after input transaction")
    `VPRC_ASSERT_IMP(a_out_range, m_tvalid, m_tdata != 24'h800000, "drive voltage out of range")

endmodule

@@ test/tb_top.sv @@
// regression testbench for the velocity pi ramp controller
module tb_top;
    import vprc_pkg::*;

    typedef struct packed {
        logic        tag;
        logic [23:0] volt;
        logic        clamped;
        logic        ramped;
    } drive_result_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [55:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [23:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_data;

    velocity_pi_ramp_controller uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
    );

    longint unsigned kp, ki, vlim, rlim;
    longint integ_st [2];
    longint err_st [2];
    longint out_st [2];
    drive_result_t pending_drive [$];
    int errors = 0;
    int burst_left = 0;
    logic stall_mode = 0;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #400000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint clamp_sym(longint v, longint lim, inout logic hit);
        if (v > lim)
        begin
            hit = 1;
            return lim;
        end
        if (v < -lim)
        begin
            hit = 1;
            return -lim;
        end
        return v;
    endfunction

    function automatic drive_result_t predict_drive(logic tag, logic [31:0] eraw,
                                                    logic [19:0] eus);
        drive_result_t r;
        longint e, p, s, inc, ig, sm, stp, d, o;
        longint unsigned ts, g, ms, mag, ea;
        logic hit;
        hit = 0;
        e = longint'($signed(eraw));
        ts = (eus == 0 || eus > 500000) ? 1000 : eus;
        ea = (e < 0) ? -e : e;
        mag = (kp * ea) >> 16;
        p = (e < 0) ? -longint'(mag) : longint'(mag);
        g = (ki * ts * 65536) / 1000000;
        s = e + err_st[tag];
        ms = (s < 0) ? -s : s;
        if (ms != 0 && g > (64'hFFFF_FFFF_FFFF_FFFF / ms))
            mag = 64'd1 << 40;
        else
            mag = (g * ms) >> 33;
        inc = (s < 0) ? -longint'(mag) : longint'(mag);
        ig = clamp_sym(integ_st[tag] + inc, longint'(vlim), hit);
        sm = clamp_sym(p + ig, longint'(vlim), hit);
        stp = longint'((rlim * ts) / 1000000);
        d = sm - out_st[tag];
        o = sm;
        r.ramped = 0;
        if (d > stp)
        begin
            o = out_st[tag] + stp;
            r.ramped = 1;
        end
        else if (d < -stp)
        begin
            o = out_st[tag] - stp;
            r.ramped = 1;
        end
        integ_st[tag] = ig;
        err_st[tag] = e;
        out_st[tag] = o;
        r.tag = tag;
        r.volt = o[23:0];
        r.clamped = hit;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, longint unsigned val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_data <= val[CFG_W-1:0];
        case (idx)
            CFG_PROP_GAIN:  kp = val & 24'hFFFFFF;
            CFG_INTEG_GAIN: ki = val & 24'hFFFFFF;
            CFG_VLIM:       vlim = val & 23'h7FFFFF;
            default:        rlim = val & 28'hFFFFFFF;
        endcase
        @(posedge clk);
        cfg_we <= 0;
    endtask

    task automatic wait_drained();
        if (burst_left != 0)
        begin
            burst_left = 0;
            s_tvalid <= 0;
        end
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic send_sample(logic tag, logic [31:0] err, logic [19:0] eus);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 300);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser <= tag;
        s_tdata <= {4'b0, eus, err};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_drive.push_back(predict_drive(tag, err, eus));
        if (burst_left == 0)
            s_tvalid <= 0;
    endtask

    always @(posedge clk)
    begin
        drive_result_t got, want;
        if (m_tvalid && m_tready)
        begin
            got = {m_tuser[0], m_tdata, m_tuser[1], m_tuser[2]};
            if (pending_drive.size() == 0)
            begin
                $error("unexpected transaction");
                errors++;
            end
            else
            begin
                want = pending_drive.pop_front();
                if (got.tag !== want.tag)
                begin
                    $error("motor_tag expected %0d actual %0d", want.tag, got.tag);
                    errors++;
                end
                if (got.volt !== want.volt)
                begin
                    $error("drive_voltage expected %h actual %h", want.volt, got.volt);
                    errors++;
                end
                if (got.clamped !== want.clamped)
                begin
                    $error("clamped expected %0d actual %0d", want.clamped, got.clamped);
                    errors++;
                end
                if (got.ramped !== want.ramped)
                begin
                    $error("ramp_limited expected %0d actual %0d", want.ramped, got.ramped);
                    errors++;
                end
            end
        end
        if ($urandom_range(0, 99) < 2)
            stall_mode <= ~stall_mode;
        m_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    function automatic logic [31:0] rand_error();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 400000)) - 200000);
            2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [19:0] rand_interval();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3);
            2: return $urandom_range(499990, 500010);
            default: return $urandom_range(100, 5000);
        endcase
    endfunction

    task automatic test_defaults();
        send_sample(0, 32'h0001_0000, 1000);
        send_sample(1, 32'h7FFF_FFFF, 0);
        send_sample(0, 32'h8000_0000, 20'hFFFFF);
        send_sample(1, 32'h8000_0000, 500000);
        send_sample(0, 32'h0, 500001);
        send_sample(1, 32'hFFFF_FFFF, 1);
        send_sample(0, 32'h7FFF_FFFF, 500000);
        send_sample(1, 32'h0, 1000);
        wait_drained();
    endtask

    task automatic test_extreme_gains();
        write_reg(CFG_PROP_GAIN, 24'hFFFFFF);
        write_reg(CFG_INTEG_GAIN, 24'hFFFFFF);
        write_reg(CFG_VLIM, 23'h7FFFFF);
        write_reg(CFG_RAMP, 28'hFFFFFFF);
        send_sample(0, 32'h7FFF_FFFF, 500000);
        send_sample(0, 32'h7FFF_FFFF, 500000);
        send_sample(1, 32'h8000_0000, 20'hFFFFF);
        send_sample(1, 32'h8000_0000, 500000);
        send_sample(0, 32'h0000_0001, 1);
        wait_drained();
        write_reg(CFG_PROP_GAIN, 0);
        write_reg(CFG_INTEG_GAIN, 0);
        write_reg(CFG_RAMP, 0);
        send_sample(0, 32'h1234_5678, 1000);
        send_sample(1, 32'h8765_4321, 0);
        wait_drained();
        write_reg(CFG_VLIM, 0);
        write_reg(CFG_RAMP, 28'hFFFFFFF);
        send_sample(0, 32'h0100_0000, 1000);
        send_sample(1, 32'hFF00_0000, 1000);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int k;
        for (k = 0; k < count; k++)
        begin
            if (k % 120 == 0)
            begin
                wait_drained();
                write_reg(CFG_PROP_GAIN, $urandom_range(0, 1) ? $urandom_range(0, 200000)
                                                              : 24'($urandom));
                write_reg(CFG_INTEG_GAIN, $urandom_range(0, 1) ? $urandom_range(0, 2000000)
                                                               : 24'($urandom));
                write_reg(CFG_VLIM, $urandom_range(0, 3) ? $urandom_range(0, 2000000)
                                                         : 23'($urandom));
                write_reg(CFG_RAMP, $urandom_range(0, 1) ? $urandom_range(0, 50000000)
                                                         : 28'($urandom));
            end
            send_sample($urandom_range(0, 1), rand_error(), rand_interval());
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        m_tready = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_data = 0;
        kp = 4456;
        ki = 2425;
        vlim = 786432;
        rlim = 6553600;
        for (int m = 0; m < 2; m++)
        begin
            integ_st[m] = 0;
            err_st[m] = 0;
            out_st[m] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_defaults();
        test_extreme_gains();
        test_random(1130);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
